>>> src/assert_macros.svh
// assertion macros used by the checker file
// no dependencies; clock clk and reset rst are taken from the enclosing scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent holds -> consequent holds in the same cycle
`define WANEF_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// antecedent holds -> consequent holds in the next cycle
`define WANEF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

>>> src/wanef_pkg.sv
// types, constants and helper functions for the weekly alarm next event finder
// no dependencies
package wanef_pkg;

  localparam int NUM_OFFSETS = 8;
  localparam int DAYS_PER_WEEK = 7;
  localparam int KEY_W = 11;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef logic [KEY_W-1:0] key_t;

  typedef struct packed {
    logic       enabled;
    logic [6:0] days;
    logic [4:0] hour;
    logic [5:0] minute;
  } entry_t;

  typedef struct packed {
    logic                        valid;
    logic [2:0]                  weekday;
    key_t                        now_key;
    logic [NUM_OFFSETS-1:0]      hit;
    key_t [NUM_OFFSETS-1:0]      best;
  } token_t;

  // bit position in the day mask for weekday (1..7) plus offset days
  function automatic logic [2:0] day_pos(input logic [2:0] weekday, input logic [2:0] off);
    logic [3:0] s;
    s = 4'(weekday) - 4'd1 + 4'(off);
    if (s >= 4'(DAYS_PER_WEEK)) begin
      s = s - 4'(DAYS_PER_WEEK);
    end
    return s[2:0];
  endfunction

endpackage

>>> src/wanef_cell.sv
// one table slot of the chain: holds an entry and folds it into the passing query token
// depends on wanef_pkg
module wanef_cell (
  input  logic              clk,
  input  logic              rst,
  input  logic              wr_en,
  input  wanef_pkg::entry_t wr_entry,
  input  wanef_pkg::token_t tok_in,
  output wanef_pkg::token_t tok_out
);
  import wanef_pkg::*;

  entry_t     ent;
  token_t     tok_next;
  key_t       key;
  logic [2:0] pos;
  logic       match;

  always_ff @(posedge clk) begin
    if (rst) begin
      ent <= '0;
    end else if (wr_en) begin
      ent <= wr_entry;
    end
  end

  always_comb begin
    tok_next = tok_in;
    key = {ent.hour, ent.minute};
    pos = '0;
    match = 1'b0;
    for (int o = 0; o < NUM_OFFSETS; o++) begin
      pos = day_pos(tok_in.weekday, 3'(o));
      match = ent.enabled && ent.days[pos] && ((o != 0) || (key > tok_in.now_key));
      if (match && (!tok_next.hit[o] || (key < tok_next.best[o]))) begin
        tok_next.hit[o] = 1'b1;
        tok_next.best[o] = key;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.valid <= 1'b0;
    end else begin
      tok_out <= tok_next;
    end
  end

endmodule

>>> src/wanef_pick.sv
// end of the chain: picks the first day offset with a hit and registers the result
// depends on wanef_pkg
module wanef_pick (
  input  logic              clk,
  input  logic              rst,
  input  logic              zero_done,
  input  wanef_pkg::token_t tok_in,
  output logic              done,
  output logic              found,
  output logic [2:0]        alarm_weekday,
  output logic [4:0]        alarm_hour,
  output logic [5:0]        alarm_minute
);
  import wanef_pkg::*;

  logic [2:0] sel;
  logic       any;
  key_t       best;
  logic [2:0] day;

  always_comb begin
    sel = '0;
    any = 1'b0;
    for (int o = NUM_OFFSETS - 1; o >= 0; o--) begin
      if (tok_in.hit[o]) begin
        sel = 3'(o);
        any = 1'b1;
      end
    end
    best = tok_in.best[sel];
    day = day_pos(tok_in.weekday, sel) + 3'd1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= zero_done || tok_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (tok_in.valid && any) begin
      found <= 1'b1;
      alarm_weekday <= day;
      alarm_hour <= best[10:6];
      alarm_minute <= best[5:0];
    end else begin
      found <= 1'b0;
      alarm_weekday <= '0;
      alarm_hour <= '0;
      alarm_minute <= '0;
    end
  end

endmodule

>>> src/weekly_alarm_next_event_finder_core.sv
// top level of the weekly alarm next event finder: cell chain plus result picker
// depends on wanef_pkg, wanef_cell, wanef_pick
//
// usage
// - a transaction is taken at a rising edge with start high and busy low
// - op write loads entry_index with enable, day mask, hour and minute; slots at or
//   above MAX_ENTRIES are dropped; the result (all zero) shows in the next cycle
// - op query sends a token down a chain of MAX_ENTRIES cells, one cell per cycle,
//   each folding its entry into the earliest time per day offset; the picker
//   then selects the first offset with a hit
// - a query passes the chain cells and then the picker register; busy stays high
//   until done, so a new transaction is taken only once the last query is through
// - a query with weekday 0 answers all zero in the next cycle
// - each result is shown for one cycle with done high; the receiver cannot stall
// - reset clears every table entry (disabled), the chain valid flags and the result strobe
module weekly_alarm_next_event_finder_core #(
  parameter int MAX_ENTRIES = 8
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  logic       op,
  input  logic [2:0] entry_index,
  input  logic       entry_enabled,
  input  logic [6:0] entry_days,
  input  logic [4:0] entry_hour,
  input  logic [5:0] entry_minute,
  input  logic [2:0] now_weekday,
  input  logic [4:0] now_hour,
  input  logic [5:0] now_minute,
  output logic       done,
  output logic       found,
  output logic [2:0] alarm_weekday,
  output logic [4:0] alarm_hour,
  output logic [5:0] alarm_minute
);
  import wanef_pkg::*;

  logic   accept;
  logic   query_acc;
  logic   write_acc;
  entry_t wr_entry;
  token_t tok [MAX_ENTRIES+1];

  assign accept = start && !busy;
  assign query_acc = accept && (op == OP_QUERY) && (now_weekday != 3'd0);
  assign write_acc = accept && (op == OP_WRITE) && (32'(entry_index) < MAX_ENTRIES);
  assign wr_entry = '{enabled: entry_enabled, days: entry_days,
                      hour: entry_hour, minute: entry_minute};

  always_comb begin
    tok[0] = '0;
    tok[0].valid = query_acc;
    tok[0].weekday = now_weekday;
    tok[0].now_key = {now_hour, now_minute};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (query_acc) begin
      busy <= 1'b1;
    end else if (tok[MAX_ENTRIES].valid) begin
      busy <= 1'b0;
    end
  end

  for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
    wanef_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .wr_en    (write_acc && (32'(entry_index) == i)),
      .wr_entry (wr_entry),
      .tok_in   (tok[i]),
      .tok_out  (tok[i+1])
    );
  end

  wanef_pick u_pick (
    .clk           (clk),
    .rst           (rst),
    .zero_done     (accept && !query_acc),
    .tok_in        (tok[MAX_ENTRIES]),
    .done          (done),
    .found         (found),
    .alarm_weekday (alarm_weekday),
    .alarm_hour    (alarm_hour),
    .alarm_minute  (alarm_minute)
  );

endmodule

>>> src/wanef_checker.sv
// port-level checks for the weekly alarm next event finder, bound to the top level
// depends on assert_macros.svh
`include "assert_macros.svh"

module wanef_checker (
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input logic       op,
  input logic [2:0] now_weekday,
  input logic       done,
  input logic       found,
  input logic [2:0] alarm_weekday,
  input logic [4:0] alarm_hour,
  input logic [5:0] alarm_minute
);

  `WANEF_ASSERT_NEXT(a_write_result, start && !busy && !op, done && !found)
  `WANEF_ASSERT_NEXT(a_query_busy, start && !busy && op && (now_weekday != 3'd0), busy)
  `WANEF_ASSERT_SAME(a_busy_end, $fell(busy), done)
  `WANEF_ASSERT_SAME(a_done_idle, done, !busy)
  `WANEF_ASSERT_SAME(a_fields, done && !found,
                     (alarm_weekday == 3'd0) && (alarm_hour == 5'd0) && (alarm_minute == 6'd0))

endmodule

bind weekly_alarm_next_event_finder_core wanef_checker u_wanef_checker (.*);

>>> tb/tb_weekly_alarm_next_event_finder_core.sv
// testbench for weekly_alarm_next_event_finder_core: table writes and next-alarm queries,
// each result checked against an in-bench predictor of the alarm table search
// depends on wanef_pkg and weekly_alarm_next_event_finder_core
module tb_weekly_alarm_next_event_finder_core;
  timeunit 1ns;
  timeprecision 1ps;
  import wanef_pkg::*;

  localparam int SLOTS = 8;
  localparam int IDLE_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 20;
  localparam int RANDOM_ITEMS = 1600;

  typedef struct packed {
    logic       op;
    logic [2:0] idx;
    logic       en;
    logic [6:0] days;
    logic [4:0] hr;
    logic [5:0] mn;
    logic [2:0] now_wd;
    logic [4:0] now_hr;
    logic [5:0] now_mn;
  } xact_t;

  typedef struct packed {
    logic       found;
    logic [2:0] weekday;
    logic [4:0] hour;
    logic [5:0] minute;
  } alarm_t;

  class alarm_scoreboard;
    entry_t slots[SLOTS];
    alarm_t awaited_q[$];
    int     errors;

    function new();
      foreach (slots[k]) slots[k] = '0;
      errors = 0;
    endfunction

    function alarm_t next_alarm(logic [2:0] wd, logic [4:0] hr, logic [5:0] mn);
      alarm_t     r;
      key_t       now_key;
      key_t       best;
      key_t       key;
      logic       hit;
      int         dn;
      r = '0;
      if (wd == 3'd0) return r;
      now_key = {hr, mn};
      for (int off = 0; off < 8; off++) begin
        dn = ((int'(wd) - 1 + off) % 7) + 1;
        hit = 1'b0;
        best = '0;
        for (int k = 0; k < SLOTS; k++) begin
          key = {slots[k].hour, slots[k].minute};
          if (slots[k].enabled && slots[k].days[dn-1] && !(off == 0 && key <= now_key) &&
              (!hit || key < best)) begin
            best = key;
            hit = 1'b1;
          end
        end
        if (hit) begin
          r.found = 1'b1;
          r.weekday = 3'(dn);
          r.hour = best[10:6];
          r.minute = best[5:0];
          return r;
        end
      end
      return r;
    endfunction

    function void note_transaction(xact_t t);
      if (t.op == OP_WRITE) begin
        if (int'(t.idx) < SLOTS) slots[t.idx] = '{t.en, t.days, t.hr, t.mn};
        awaited_q.push_back('0);
      end else begin
        awaited_q.push_back(next_alarm(t.now_wd, t.now_hr, t.now_mn));
      end
    endfunction

    function void check_result(alarm_t got);
      alarm_t exp;
      if (awaited_q.size() == 0) begin
        $error("result with no transaction outstanding");
        errors++;
        return;
      end
      exp = awaited_q.pop_front();
      if (got.found !== exp.found) begin
        $error("found: expected %0d, got %0d", exp.found, got.found);
        errors++;
      end
      if (got.weekday !== exp.weekday) begin
        $error("alarm_weekday: expected %0d, got %0d", exp.weekday, got.weekday);
        errors++;
      end
      if (got.hour !== exp.hour) begin
        $error("alarm_hour: expected %0d, got %0d", exp.hour, got.hour);
        errors++;
      end
      if (got.minute !== exp.minute) begin
        $error("alarm_minute: expected %0d, got %0d", exp.minute, got.minute);
        errors++;
      end
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       start = 1'b0;
  logic       busy;
  logic       op = OP_WRITE;
  logic [2:0] entry_index = '0;
  logic       entry_enabled = 1'b0;
  logic [6:0] entry_days = '0;
  logic [4:0] entry_hour = '0;
  logic [5:0] entry_minute = '0;
  logic [2:0] now_weekday = '0;
  logic [4:0] now_hour = '0;
  logic [5:0] now_minute = '0;
  logic       done;
  logic       found;
  logic [2:0] alarm_weekday;
  logic [4:0] alarm_hour;
  logic [5:0] alarm_minute;

  alarm_scoreboard board;
  int burst_left = 0;
  int idle_cycles = 0;

  weekly_alarm_next_event_finder_core u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .op(op),
    .entry_index(entry_index), .entry_enabled(entry_enabled), .entry_days(entry_days),
    .entry_hour(entry_hour), .entry_minute(entry_minute), .now_weekday(now_weekday),
    .now_hour(now_hour), .now_minute(now_minute), .done(done), .found(found),
    .alarm_weekday(alarm_weekday), .alarm_hour(alarm_hour), .alarm_minute(alarm_minute)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst && done) board.check_result('{found, alarm_weekday, alarm_hour, alarm_minute});
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // called at a rising edge; returns at the accepting edge or after the gap
  task automatic send_item(input xact_t t);
    op <= t.op;
    entry_index <= t.idx;
    entry_enabled <= t.en;
    entry_days <= t.days;
    entry_hour <= t.hr;
    entry_minute <= t.mn;
    now_weekday <= t.now_wd;
    now_hour <= t.now_hr;
    now_minute <= t.now_mn;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    board.note_transaction(t);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      start <= 1'b0;
      burst_left = $urandom_range(0, 40);
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  endtask

  task automatic write_entry(input logic [2:0] idx, input logic en, input logic [6:0] days,
                             input logic [4:0] hr, input logic [5:0] mn);
    xact_t       t;
    logic [63:0] rnd;
    rnd = {$urandom, $urandom};
    t = xact_t'(rnd[$bits(xact_t)-1:0]);
    t.op = OP_WRITE;
    t.idx = idx;
    t.en = en;
    t.days = days;
    t.hr = hr;
    t.mn = mn;
    send_item(t);
  endtask

  task automatic query_next(input logic [2:0] wd, input logic [4:0] hr, input logic [5:0] mn);
    xact_t       t;
    logic [63:0] rnd;
    rnd = {$urandom, $urandom};
    t = xact_t'(rnd[$bits(xact_t)-1:0]);
    t.op = OP_QUERY;
    t.now_wd = wd;
    t.now_hr = hr;
    t.now_mn = mn;
    send_item(t);
  endtask

  initial begin
    int         n;
    int         k;
    logic [6:0] days;
    logic [4:0] hr;
    logic [5:0] mn;
    board = new();
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // empty table, weekday zero, last minute of the day
    query_next(3'd1, 5'd0, 6'd0);
    query_next(3'd0, 5'd12, 6'd0);
    write_entry(3'd0, 1'b1, 7'h7f, 5'd23, 6'd59);
    query_next(3'd3, 5'd23, 6'd58);
    query_next(3'd3, 5'd23, 6'd59);
    query_next(3'd0, 5'd0, 6'd0);
    write_entry(3'd7, 1'b1, 7'h40, 5'd0, 6'd0);
    query_next(3'd7, 5'd0, 6'd0);
    write_entry(3'd0, 1'b0, 7'h7f, 5'd23, 6'd59);
    // same weekday next week, regardless of now
    query_next(3'd7, 5'd12, 6'd0);
    query_next(3'd7, 5'd0, 6'd0);
    query_next(3'd1, 5'd0, 6'd0);
    // hour and minute beyond the clock range
    write_entry(3'd3, 1'b1, 7'h01, 5'd31, 6'd63);
    query_next(3'd1, 5'd31, 6'd62);
    query_next(3'd1, 5'd31, 6'd63);
    write_entry(3'd5, 1'b1, 7'h00, 5'd5, 6'd5);
    // two entries on the same time
    write_entry(3'd1, 1'b1, 7'h08, 5'd6, 6'd30);
    write_entry(3'd2, 1'b1, 7'h18, 5'd6, 6'd30);
    query_next(3'd4, 5'd0, 6'd0);
    query_next(3'd5, 5'd6, 6'd30);
    write_entry(3'd7, 1'b1, 7'h00, 5'd0, 6'd0);
    write_entry(3'd3, 1'b0, 7'h01, 5'd31, 6'd63);
    query_next(3'd2, 5'd0, 6'd0);

    n = 0;
    while (n < RANDOM_ITEMS) begin
      repeat ($urandom_range(0, 3)) begin
        case ($urandom_range(0, 3))
          0: days = 7'(1 << $urandom_range(0, 6));
          1: days = 7'h7f;
          default: days = 7'($urandom);
        endcase
        hr = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(0, 31)) : 5'($urandom_range(0, 23));
        case ($urandom_range(0, 9))
          0: mn = 6'($urandom_range(0, 63));
          1: mn = 6'd59;
          default: mn = 6'($urandom_range(0, 59));
        endcase
        write_entry(3'($urandom_range(0, 7)), $urandom_range(0, 9) != 0, days, hr, mn);
        n++;
      end
      repeat ($urandom_range(1, 8)) begin
        k = $urandom_range(0, SLOTS - 1);
        case ($urandom_range(0, 9))
          0, 1, 2: begin
            hr = board.slots[k].hour;
            mn = board.slots[k].minute;
          end
          3: begin
            hr = 5'($urandom_range(0, 31));
            mn = 6'($urandom_range(0, 63));
          end
          default: begin
            hr = 5'($urandom_range(0, 23));
            mn = 6'($urandom_range(0, 59));
          end
        endcase
        query_next(($urandom_range(0, 24) == 0) ? 3'd0 : 3'($urandom_range(1, 7)), hr, mn);
        n++;
      end
    end

    start <= 1'b0;
    while (board.awaited_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (board.errors == 0 && board.awaited_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
